// ----- rtl/slp_pkg.sv -----
// ----------------------------------------------------------------------------
// slp_pkg: shared types, constants and helpers
// Command codes, register indexes, controller/datapath handshake types and
// saturating Q32.32 arithmetic used by the projection block.
// ----------------------------------------------------------------------------
package slp_pkg;

	localparam int MAX_ELEMS_DEF = 4096;
	localparam int CW            = 13;   // group counts, length, cutoff
	localparam int IW            = 12;   // element index
	localparam int VW            = 64;   // Q32.32 value
	localparam int CFG_IW        = 3;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_RUN  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_K_COUNT     = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_ALPHA_LIMIT = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_START_UNTIED = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_START_TIED  = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_CUTOFF      = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_LENGTH      = 3'd5;

	localparam logic [IW-1:0]        K_COUNT_RST = 12'd1;
	localparam logic signed [VW-1:0] ALPHA_RST   = 64'sd0;
	localparam logic [CW-1:0]        UNTIED_RST  = 13'd1;
	localparam logic [CW-1:0]        TIED_RST    = 13'd0;
	localparam logic [CW-1:0]        CUTOFF_RST  = 13'd4096;
	localparam logic [CW-1:0]        LENGTH_RST  = 13'd4096;

	// 1e-9 in Q32.32
	localparam logic signed [VW-1:0] TOL_Q = 64'sd4;
	localparam logic signed [VW-1:0] SMAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [VW-1:0] SMIN  = 64'sh8000_0000_0000_0000;

	typedef enum logic [5:0] {
		OP_NONE, OP_LOAD, OP_READ_ADDR, OP_RUN_START,
		OP_SUM_RD, OP_SUM_ACC, OP_TIE_RD, OP_TIE_LD, OP_LAST_RD, OP_LAST_LD,
		OP_COEF_A, OP_COEF_B, OP_COEF_C, OP_COEF_D,
		OP_S1_GO, OP_S1_WAIT, OP_S2_GO, OP_S2_WAIT, OP_SEL,
		OP_A_GO, OP_A_WAIT, OP_B_GO, OP_B_WAIT, OP_C_GO, OP_C_WAIT,
		OP_UPD, OP_ULAST_RD, OP_ULAST_LD, OP_NEXT_RD, OP_NEXT_LD,
		OP_WB_START, OP_WB_RD, OP_WB_SUB, OP_WB_TIE,
		OP_RESP_READ, OP_RESP_RUN
	} dp_op_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_READ, ST_SUM_RD, ST_SUM_ACC, ST_TIE_RD, ST_TIE_LD,
		ST_LAST_RD, ST_LAST_LD, ST_CHECK,
		ST_COEF_A, ST_COEF_B, ST_COEF_C, ST_COEF_D,
		ST_S1_GO, ST_S1_WAIT, ST_S2_GO, ST_S2_WAIT, ST_SEL,
		ST_A_GO, ST_A_WAIT, ST_B_GO, ST_B_WAIT, ST_C_GO, ST_C_WAIT,
		ST_UPD, ST_POST, ST_ULAST_RD, ST_ULAST_LD, ST_NEXT_RD, ST_NEXT_LD,
		ST_WB_START, ST_WB_CHECK, ST_WB_RD, ST_WB_SUB, ST_WB_TIE, ST_RUN_RESP
	} ctl_state_t;

	typedef enum logic [2:0] {
		MD_IDLE, MD_LO, MD_HI, MD_SUM, MD_DIV, MD_DONE
	} md_state_t;

	typedef struct packed {
		dp_op_t op;
		logic   md_start;
	} dp_cmd_t;

	typedef struct packed {
		logic md_done;
		logic sum_last;
		logic loop_go;
		logic v1;
		logic v2;
		logic t_pos;
		logic u_pos;
		logic need_next;
		logic wb_more;
		logic wb_untied;
	} dp_status_t;

	function automatic logic signed [VW-1:0] sadd(input logic signed [VW-1:0] a,
			input logic signed [VW-1:0] b);
		logic signed [VW:0] r;
		r = {a[VW-1], a} + {b[VW-1], b};
		if (r[VW] != r[VW-1]) return r[VW] ? SMIN : SMAX;
		return r[VW-1:0];
	endfunction

	function automatic logic signed [VW-1:0] ssub(input logic signed [VW-1:0] a,
			input logic signed [VW-1:0] b);
		logic signed [VW:0] r;
		r = {a[VW-1], a} - {b[VW-1], b};
		if (r[VW] != r[VW-1]) return r[VW] ? SMIN : SMAX;
		return r[VW-1:0];
	endfunction

endpackage

// ----- rtl/slp_muldiv.sv -----
// ----------------------------------------------------------------------------
// slp_muldiv: exact scaled product trunc(a*b/d), saturated
// Two 32x32 partial products, then a restoring divide one quotient bit
// per cycle over the 96-bit product.
// ----------------------------------------------------------------------------
module slp_muldiv import slp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [VW-1:0] a,
	input  logic signed [31:0]   b,
	input  logic signed [31:0]   dv,
	output logic                 done,
	output logic signed [VW-1:0] q
);
	localparam int PW   = 96;
	localparam int CNTW = $clog2(PW);

	md_state_t         st_q;
	logic              neg_q;
	logic [VW-1:0]     am_q;
	logic [31:0]       bm_q, dm_q, rem_q;
	logic [63:0]       lo_q, hi_q;
	logic [PW-1:0]     p_q;
	logic [CNTW-1:0]   cnt_q;
	logic [32:0]       trial;
	logic              ge;
	logic [VW-1:0]     qlo;
	logic              ovf;

	assign trial = {rem_q, p_q[PW-1]};
	assign ge    = trial >= {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= MD_IDLE;
		end else begin
			unique case (st_q)
				MD_IDLE: if (start) st_q <= MD_LO;
				MD_LO:   st_q <= MD_HI;
				MD_HI:   st_q <= MD_SUM;
				MD_SUM:  st_q <= MD_DIV;
				MD_DIV:  if (cnt_q == CNTW'(PW - 1)) st_q <= MD_DONE;
				MD_DONE: st_q <= MD_IDLE;
				default: st_q <= MD_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			MD_IDLE: begin
				neg_q <= a[VW-1] ^ b[31] ^ dv[31];
				am_q  <= a[VW-1] ? (~a + 64'd1) : a;
				bm_q  <= b[31] ? (~b + 32'd1) : b;
				dm_q  <= dv[31] ? (~dv + 32'd1) : dv;
			end
			MD_LO: lo_q <= 64'(am_q[31:0]) * 64'(bm_q);
			MD_HI: hi_q <= 64'(am_q[63:32]) * 64'(bm_q);
			MD_SUM: begin
				p_q   <= {32'd0, lo_q} + {hi_q, 32'd0};
				rem_q <= '0;
				cnt_q <= '0;
			end
			MD_DIV: begin
				rem_q <= ge ? 32'(trial - {1'b0, dm_q}) : trial[31:0];
				p_q   <= {p_q[PW-2:0], ge};
				cnt_q <= cnt_q + CNTW'(1);
			end
			default: ;
		endcase
	end

	assign qlo  = p_q[VW-1:0];
	assign ovf  = |p_q[PW-1:VW];
	assign done = st_q == MD_DONE;

	always_comb begin
		if (dm_q == '0)
			q = '0;
		else if (ovf || qlo[VW-1])
			q = neg_q ? SMIN : SMAX;
		else if (neg_q)
			q = -$signed(qlo);
		else
			q = $signed(qlo);
	end

endmodule

// ----- rtl/slp_datapath.sv -----
// ----------------------------------------------------------------------------
// slp_datapath: element store, pivot registers and arithmetic
// Executes one operation per cycle as selected by the controller and reports
// loop and branch conditions back to it.
// ----------------------------------------------------------------------------
module slp_datapath import slp_pkg::*; #(
	parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               ctl,
	output dp_status_t            sts,
	input  logic                  cfg_we,
	input  logic [CFG_IW-1:0]     cfg_index,
	input  logic [VW-1:0]         cfg_data,
	input  logic [IW-1:0]         index,
	input  logic signed [VW-1:0]  value_in,
	output logic signed [VW-1:0]  value_out,
	output logic [CW-1:0]         untied_count,
	output logic [CW-1:0]         tied_count,
	output logic                  complete
);
	localparam int AW = $clog2(MAX_ELEMS);
	localparam logic signed [CW+1:0] ONE_S = 1;

	// configuration
	logic [IW-1:0]        kc_q;
	logic signed [VW-1:0] alpha_q;
	logic [CW-1:0]        su_q, stied_q, cut_q, len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q    <= K_COUNT_RST;
			alpha_q <= ALPHA_RST;
			su_q    <= UNTIED_RST;
			stied_q <= TIED_RST;
			cut_q   <= CUTOFF_RST;
			len_q   <= LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_K_COUNT:      kc_q    <= cfg_data[IW-1:0];
				CFG_ALPHA_LIMIT:  alpha_q <= $signed(cfg_data);
				CFG_START_UNTIED: su_q    <= cfg_data[CW-1:0];
				CFG_START_TIED:   stied_q <= cfg_data[CW-1:0];
				CFG_CUTOFF:       cut_q   <= cfg_data[CW-1:0];
				CFG_LENGTH:       len_q   <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// element store
	logic signed [VW-1:0] mem [MAX_ELEMS];
	logic [AW-1:0]        rd_addr, wr_addr;
	logic                 we;
	logic signed [VW-1:0] wr_data, rd_q;

	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// pivot state
	logic [CW-1:0]          n_q, k_q, u_q, t_q, fu_q, ft_q, iter_q, idx_q;
	logic signed [VW-1:0]   sum_q, dec_q, tie_q, last_q, next_q, lim_q, s_q, s1_q, s2_q;
	logic [25:0]            ut_q;
	logic signed [27:0]     mm_q;
	logic signed [31:0]     d_q, c_q;
	logic signed [CW+1:0]   nu_q, nt_q, np_q;
	logic signed [28:0]     p1_q, p2_q;
	logic                   v1_q, v2_q, rng_q;

	logic                   in_rng;
	logic [CW-1:0]          n_nx, k_nx, u_nx, t_nx;
	logic signed [CW:0]     m;
	logic                   m_pos;
	logic [CW:0]            ut_sum, idx_inc, fsum, tp;
	logic signed [31:0]     d_nx;
	logic signed [CW+1:0]   t_s, m_s, nu_nx, nt_nx, np_nx;
	logic signed [VW-1:0]   s_sel, md_a, md_q;
	logic signed [31:0]     md_b, md_d;
	logic                   md_done;

	assign in_rng  = 32'(index) < MAX_ELEMS;
	assign m       = $signed({1'b0, k_q}) - $signed({1'b0, u_q});
	assign m_pos   = !m[CW] && (m != '0);
	assign ut_sum  = {1'b0, u_q} + {1'b0, t_q};
	assign idx_inc = {1'b0, idx_q} + (CW+1)'(1);
	assign fsum    = {1'b0, fu_q} + {1'b0, ft_q};
	assign t_s     = $signed({2'b00, t_q});
	assign m_s     = (CW+2)'(m);

	// clamped run parameters
	always_comb begin
		if (32'(len_q) > MAX_ELEMS)
			n_nx = CW'(MAX_ELEMS);
		else if (len_q < CW'(2))
			n_nx = CW'(2);
		else
			n_nx = len_q;
		k_nx = CW'(kc_q);
		if (k_nx > n_nx - CW'(1)) k_nx = n_nx - CW'(1);
		if (k_nx == '0) k_nx = CW'(1);
		u_nx = (su_q > n_nx) ? n_nx : su_q;
	end

	// pivot slopes
	always_comb begin
		d_nx  = m_pos ? $signed(32'(ut_q)) + 32'(mm_q) : $signed(32'(k_q));
		nu_nx = m_pos ? ((u_q != '0) ? t_s : m_s) : ONE_S;
		if (t_q != '0)
			nt_nx = m_pos ? m_s : ONE_S;
		else
			nt_nx = '0;
		np_nx = (t_q == '0) ? nu_nx : nt_nx;
	end

	always_comb begin
		s_sel = ssub(sum_q, alpha_q);
		if (v2_q && s2_q < s_sel) s_sel = s2_q;
		if (v1_q && s1_q < s_sel) s_sel = s1_q;
	end

	// tied group grows by one, at least to two, never past n
	always_comb begin
		tp   = ((t_q == '0) ? (CW+1)'(1) : {1'b0, t_q}) + (CW+1)'(1);
		t_nx = (tp > {1'b0, n_q}) ? n_q : tp[CW-1:0];
	end

	always_comb begin
		md_a = s_q;
		md_b = c_q;
		md_d = d_q;
		unique case (ctl.op)
			OP_S1_GO: begin
				md_a = ssub(tie_q, last_q);
				md_b = d_q;
				md_d = 32'(nt_q) - 32'(nu_q);
			end
			OP_S2_GO: begin
				md_a = ssub(next_q, (t_q == '0) ? last_q : tie_q);
				md_b = d_q;
				md_d = -32'(np_q);
			end
			OP_B_GO: md_b = 32'(nt_q);
			OP_C_GO: md_b = 32'(nu_q);
			default: ;
		endcase
	end

	slp_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.md_start),
		.a      (md_a),
		.b      (md_b),
		.dv     (md_d),
		.done   (md_done),
		.q      (md_q)
	);

	// store port selection
	always_comb begin
		rd_addr = AW'(idx_q);
		wr_addr = AW'(idx_q);
		wr_data = tie_q;
		we      = 1'b0;
		unique case (ctl.op)
			OP_READ_ADDR: rd_addr = AW'(index);
			OP_TIE_RD:    rd_addr = AW'(k_q);
			OP_LAST_RD:   rd_addr = AW'(k_q - CW'(1));
			OP_ULAST_RD:  rd_addr = AW'(u_q - CW'(1));
			OP_NEXT_RD:   rd_addr = AW'(ut_sum);
			OP_LOAD: begin
				wr_addr = AW'(index);
				wr_data = value_in;
				we      = in_rng;
			end
			OP_WB_SUB: begin
				wr_data = ssub(rd_q, dec_q);
				we      = 1'b1;
			end
			OP_WB_TIE: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_READ_ADDR: rng_q <= in_rng;
			OP_RUN_START: begin
				n_q    <= n_nx;
				k_q    <= k_nx;
				u_q    <= u_nx;
				t_q    <= (stied_q > n_nx) ? n_nx : stied_q;
				sum_q  <= '0;
				dec_q  <= '0;
				fu_q   <= '0;
				ft_q   <= '0;
				iter_q <= '0;
				idx_q  <= '0;
				lim_q  <= sadd(alpha_q, TOL_Q);
			end
			OP_SUM_ACC: begin
				sum_q <= sadd(sum_q, rd_q);
				idx_q <= idx_q + CW'(1);
			end
			OP_TIE_LD: begin
				tie_q  <= rd_q;
				next_q <= rd_q;
			end
			OP_LAST_LD: last_q <= rd_q;
			OP_COEF_A: begin
				ut_q <= 26'(u_q) * 26'(t_q);
				mm_q <= 28'(m) * 28'(m);
			end
			OP_COEF_B: begin
				d_q  <= d_nx;
				nu_q <= nu_nx;
				nt_q <= nt_nx;
				np_q <= np_nx;
				v1_q <= (u_q != '0) && (nt_nx != nu_nx);
				v2_q <= (ut_sum < {1'b0, n_q}) && (np_nx != '0);
			end
			OP_COEF_C: begin
				p1_q <= 29'($signed({1'b0, u_q})) * 29'(nu_q);
				p2_q <= 29'(m) * 29'(nt_q);
			end
			OP_COEF_D: c_q <= 32'(p1_q) + 32'(p2_q);
			OP_S1_WAIT: if (md_done) s1_q <= md_q;
			OP_S2_WAIT: if (md_done) s2_q <= md_q;
			OP_SEL: s_q <= s_sel;
			OP_A_WAIT: if (md_done) sum_q <= ssub(sum_q, md_q);
			OP_B_WAIT: if (md_done) tie_q <= ssub(tie_q, md_q);
			OP_C_WAIT: if (md_done) dec_q <= sadd(dec_q, md_q);
			OP_UPD: begin
				fu_q   <= u_q;
				ft_q   <= t_q;
				if (v1_q && s_q == s1_q && u_q != '0) u_q <= u_q - CW'(1);
				t_q    <= t_nx;
				iter_q <= iter_q + CW'(1);
			end
			OP_ULAST_LD: last_q <= ssub(rd_q, dec_q);
			OP_NEXT_LD:  next_q <= rd_q;
			OP_WB_START: idx_q <= '0;
			OP_WB_SUB, OP_WB_TIE: idx_q <= idx_q + CW'(1);
			OP_RESP_READ: begin
				value_out    <= rng_q ? rd_q : '0;
				untied_count <= '0;
				tied_count   <= '0;
				complete     <= 1'b0;
			end
			OP_RESP_RUN: begin
				value_out    <= '0;
				untied_count <= fu_q;
				tied_count   <= ft_q;
				complete     <= sum_q <= lim_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.md_done   = md_done;
		sts.sum_last  = idx_inc >= {1'b0, k_q};
		sts.loop_go   = (sum_q > lim_q) && (iter_q < n_q) && (ut_sum <= {1'b0, cut_q});
		sts.v1        = v1_q;
		sts.v2        = v2_q;
		sts.t_pos     = t_q != '0;
		sts.u_pos     = u_q != '0;
		sts.need_next = ut_sum < {1'b0, n_q};
		sts.wb_more   = ({1'b0, idx_q} < fsum) && (idx_q < n_q);
		sts.wb_untied = idx_q < fu_q;
	end

endmodule

// ----- rtl/slp_ctrl.sv -----
// ----------------------------------------------------------------------------
// slp_ctrl: command sequencer
// Accepts commands, steps the datapath through load, read, sum, pivot loop
// and write-back, and owns the result valid flag.
// ----------------------------------------------------------------------------
module slp_ctrl import slp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] cmd,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t sts,
	output dp_cmd_t    ctl
);
	ctl_state_t st_q, st_nx;
	logic       ov_q;
	logic       acc;

	assign in_ready  = (st_q == ST_IDLE) && (!ov_q || out_ready);
	assign acc       = in_valid && in_ready;
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (st_q == ST_READ || st_q == ST_RUN_RESP)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (acc && cmd == CMD_RUN)  st_nx = ST_SUM_RD;
				if (acc && cmd == CMD_READ) st_nx = ST_READ;
			end
			ST_READ:     st_nx = ST_IDLE;
			ST_SUM_RD:   st_nx = ST_SUM_ACC;
			ST_SUM_ACC:  st_nx = sts.sum_last ? ST_TIE_RD : ST_SUM_RD;
			ST_TIE_RD:   st_nx = ST_TIE_LD;
			ST_TIE_LD:   st_nx = ST_LAST_RD;
			ST_LAST_RD:  st_nx = ST_LAST_LD;
			ST_LAST_LD:  st_nx = ST_CHECK;
			ST_CHECK:    st_nx = sts.loop_go ? ST_COEF_A : ST_WB_START;
			ST_COEF_A:   st_nx = ST_COEF_B;
			ST_COEF_B:   st_nx = ST_COEF_C;
			ST_COEF_C:   st_nx = ST_COEF_D;
			ST_COEF_D:   st_nx = sts.v1 ? ST_S1_GO : (sts.v2 ? ST_S2_GO : ST_SEL);
			ST_S1_GO:    st_nx = ST_S1_WAIT;
			ST_S1_WAIT:  if (sts.md_done) st_nx = sts.v2 ? ST_S2_GO : ST_SEL;
			ST_S2_GO:    st_nx = ST_S2_WAIT;
			ST_S2_WAIT:  if (sts.md_done) st_nx = ST_SEL;
			ST_SEL:      st_nx = ST_A_GO;
			ST_A_GO:     st_nx = ST_A_WAIT;
			ST_A_WAIT:   if (sts.md_done) st_nx = sts.t_pos ? ST_B_GO : ST_C_GO;
			ST_B_GO:     st_nx = ST_B_WAIT;
			ST_B_WAIT:   if (sts.md_done) st_nx = ST_C_GO;
			ST_C_GO:     st_nx = ST_C_WAIT;
			ST_C_WAIT:   if (sts.md_done) st_nx = ST_UPD;
			ST_UPD:      st_nx = ST_POST;
			ST_POST: begin
				if (sts.u_pos)          st_nx = ST_ULAST_RD;
				else if (sts.need_next) st_nx = ST_NEXT_RD;
				else                    st_nx = ST_CHECK;
			end
			ST_ULAST_RD: st_nx = ST_ULAST_LD;
			ST_ULAST_LD: st_nx = sts.need_next ? ST_NEXT_RD : ST_CHECK;
			ST_NEXT_RD:  st_nx = ST_NEXT_LD;
			ST_NEXT_LD:  st_nx = ST_CHECK;
			ST_WB_START: st_nx = ST_WB_CHECK;
			ST_WB_CHECK: begin
				if (!sts.wb_more)       st_nx = ST_RUN_RESP;
				else if (sts.wb_untied) st_nx = ST_WB_RD;
				else                    st_nx = ST_WB_TIE;
			end
			ST_WB_RD:    st_nx = ST_WB_SUB;
			ST_WB_SUB:   st_nx = ST_WB_CHECK;
			ST_WB_TIE:   st_nx = ST_WB_CHECK;
			ST_RUN_RESP: st_nx = ST_IDLE;
			default:     st_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.op       = OP_NONE;
		ctl.md_start = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (acc && cmd == CMD_LOAD) ctl.op = OP_LOAD;
				if (acc && cmd == CMD_READ) ctl.op = OP_READ_ADDR;
				if (acc && cmd == CMD_RUN)  ctl.op = OP_RUN_START;
			end
			ST_READ:     ctl.op = OP_RESP_READ;
			ST_SUM_RD:   ctl.op = OP_SUM_RD;
			ST_SUM_ACC:  ctl.op = OP_SUM_ACC;
			ST_TIE_RD:   ctl.op = OP_TIE_RD;
			ST_TIE_LD:   ctl.op = OP_TIE_LD;
			ST_LAST_RD:  ctl.op = OP_LAST_RD;
			ST_LAST_LD:  ctl.op = OP_LAST_LD;
			ST_COEF_A:   ctl.op = OP_COEF_A;
			ST_COEF_B:   ctl.op = OP_COEF_B;
			ST_COEF_C:   ctl.op = OP_COEF_C;
			ST_COEF_D:   ctl.op = OP_COEF_D;
			ST_S1_GO: begin
				ctl.op       = OP_S1_GO;
				ctl.md_start = 1'b1;
			end
			ST_S1_WAIT:  ctl.op = OP_S1_WAIT;
			ST_S2_GO: begin
				ctl.op       = OP_S2_GO;
				ctl.md_start = 1'b1;
			end
			ST_S2_WAIT:  ctl.op = OP_S2_WAIT;
			ST_SEL:      ctl.op = OP_SEL;
			ST_A_GO: begin
				ctl.op       = OP_A_GO;
				ctl.md_start = 1'b1;
			end
			ST_A_WAIT:   ctl.op = OP_A_WAIT;
			ST_B_GO: begin
				ctl.op       = OP_B_GO;
				ctl.md_start = 1'b1;
			end
			ST_B_WAIT:   ctl.op = OP_B_WAIT;
			ST_C_GO: begin
				ctl.op       = OP_C_GO;
				ctl.md_start = 1'b1;
			end
			ST_C_WAIT:   ctl.op = OP_C_WAIT;
			ST_UPD:      ctl.op = OP_UPD;
			ST_ULAST_RD: ctl.op = OP_ULAST_RD;
			ST_ULAST_LD: ctl.op = OP_ULAST_LD;
			ST_NEXT_RD:  ctl.op = OP_NEXT_RD;
			ST_NEXT_LD:  ctl.op = OP_NEXT_LD;
			ST_WB_START: ctl.op = OP_WB_START;
			ST_WB_RD:    ctl.op = OP_WB_RD;
			ST_WB_SUB:   ctl.op = OP_WB_SUB;
			ST_WB_TIE:   ctl.op = OP_WB_TIE;
			ST_RUN_RESP: ctl.op = OP_RESP_RUN;
			default: ;
		endcase
	end

endmodule

// ----- rtl/sum_largest_projection_core.sv -----
// ----------------------------------------------------------------------------
// sum_largest_projection_core: projection onto the sum-of-k-largest bound
// Top level: command channel, result channel and configuration port.
// ----------------------------------------------------------------------------
// A load is written to the store as it is accepted, and loads are accepted
// back to back. A read result passes through the registered store read and
// then the output register before it is presented. A run first sums the k
// leading elements, then runs the pivot loop: each pivot steps through the
// control states and two to five passes of the shared scaled-divide unit
// (two partial products and a 96-step restoring divide). The write-back then
// reads, decrements and rewrites each untied element and writes the tie
// value to each tied element. Commands are taken one at a time, and none is
// taken while a result waits on the output.
module sum_largest_projection_core import slp_pkg::*; #(
	parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           cmd,
	input  logic [IW-1:0]        index,
	input  logic signed [VW-1:0] value_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [VW-1:0] value_out,
	output logic [CW-1:0]        untied_count,
	output logic [CW-1:0]        tied_count,
	output logic                 complete,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IW-1:0]    cfg_index,
	input  logic [VW-1:0]        cfg_data
);
	dp_cmd_t    ctl;
	dp_status_t sts;

	// registers are writable every cycle
	assign cfg_ready = 1'b1;

	slp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	slp_datapath #(
		.MAX_ELEMS (MAX_ELEMS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.index        (index),
		.value_in     (value_in),
		.value_out    (value_out),
		.untied_count (untied_count),
		.tied_count   (tied_count),
		.complete     (complete)
	);

endmodule
